// File: hdl/vrcd_pkg.sv
package vrcd_pkg;

  // angle units: 1/2^ANGLE_FRAC_BITS degree at the outputs
  localparam int ANGLE_FRAC_BITS = 6;
  // inner arctangent units: 2^-20 degree
  localparam int INNER_FRAC = 20;
  localparam int RND_SH = INNER_FRAC - ANGLE_FRAC_BITS;

  // fixed field widths
  localparam int STATION_BITS = 24;
  localparam int VAR_BITS = 15;
  localparam int COURSE_BITS = 15;
  localparam int RADIAL_BITS = 15;
  localparam int DEV_BITS = 14;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_STATION_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STATION_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAG_VAR   = 2'd2;

  // arctangent table and angle accumulator
  localparam int TABLE_LEN = 24;
  localparam int TBL_W = 28;
  localparam int ZW = TBL_W + 1;
  localparam logic [TBL_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
    28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121,
    28'd3750058,  28'd1876857,  28'd938658,   28'd469357,
    28'd234682,   28'd117342,   28'd58671,    28'd29335,
    28'd14668,    28'd7334,     28'd3667,     28'd1833,
    28'd917,      28'd458,      28'd229,      28'd115,
    28'd57,       28'd29,       28'd14,       28'd7
  };
  localparam logic [TBL_W-1:0] QUARTER_IN = TBL_W'(90 << INNER_FRAC);
  localparam logic [TBL_W-1:0] RND_HALF = TBL_W'(1 << (RND_SH - 1));
  localparam int T_W = TBL_W - RND_SH;

  // working angle arithmetic, signed
  localparam int ANG_W = 17;
  localparam logic signed [ANG_W-1:0] FULL_ANG    = ANG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] HALF_ANG    = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] QUARTER_ANG = ANG_W'(90 << ANGLE_FRAC_BITS);

  // per-request sideband carried along the pipeline
  typedef struct packed {
    logic [COURSE_BITS-1:0] course;
    logic                   dx_zero;
    logic                   dx_neg;
    logic                   dy_zero;
    logic                   dy_neg;
  } side_t;

endpackage

// File: hdl/vrcd_cordic_stage.sv
module vrcd_cordic_stage #(
  parameter int CW = 28,
  parameter int STAGE = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  logic signed [CW-1:0]     x_in,
  input  logic signed [CW-1:0]     y_in,
  input  logic signed [vrcd_pkg::ZW-1:0] z_in,
  input  vrcd_pkg::side_t          side_in,
  output logic                     valid_out,
  output logic signed [CW-1:0]     x_out,
  output logic signed [CW-1:0]     y_out,
  output logic signed [vrcd_pkg::ZW-1:0] z_out,
  output vrcd_pkg::side_t          side_out
);
  import vrcd_pkg::*;

  localparam logic signed [ZW-1:0] ENTRY = $signed({1'b0, ATAN_TABLE[STAGE]});

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 y_pos;

  // floor shifts of the old values
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;
  assign y_pos = !y_in[CW-1] && (y_in != '0);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // one micro-rotation
  always_ff @(posedge clk) begin
    if (y_pos) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ENTRY;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ENTRY;
    end
    side_out <= side_in;
  end

endmodule

// File: hdl/vrcd_cordic.sv
module vrcd_cordic #(
  parameter int CW = 28,
  parameter int ARCTAN_STAGES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  logic signed [CW-1:0]     x_in,
  input  logic signed [CW-1:0]     y_in,
  input  vrcd_pkg::side_t          side_in,
  output logic                     valid_out,
  output logic signed [vrcd_pkg::ZW-1:0] z_out,
  output vrcd_pkg::side_t          side_out
);
  import vrcd_pkg::*;

  localparam int N = (ARCTAN_STAGES < TABLE_LEN) ? ARCTAN_STAGES : TABLE_LEN;

  logic                 vld  [0:N];
  logic signed [CW-1:0] xv   [0:N];
  logic signed [CW-1:0] yv   [0:N];
  logic signed [ZW-1:0] zv   [0:N];
  side_t                sv   [0:N];

  assign vld[0] = valid_in;
  assign xv[0]  = x_in;
  assign yv[0]  = y_in;
  assign zv[0]  = '0;
  assign sv[0]  = side_in;

  // one registered rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    vrcd_cordic_stage #(
      .CW    (CW),
      .STAGE (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[i]),
      .x_in      (xv[i]),
      .y_in      (yv[i]),
      .z_in      (zv[i]),
      .side_in   (sv[i]),
      .valid_out (vld[i+1]),
      .x_out     (xv[i+1]),
      .y_out     (yv[i+1]),
      .z_out     (zv[i+1]),
      .side_out  (sv[i+1])
    );
  end

  assign valid_out = vld[N];
  assign z_out     = zv[N];
  assign side_out  = sv[N];

endmodule

// File: hdl/vrcd_angle.sv
module vrcd_angle (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_in,
  input  logic signed [vrcd_pkg::ZW-1:0]       z_in,
  input  vrcd_pkg::side_t                      side_in,
  input  logic signed [vrcd_pkg::VAR_BITS-1:0] variation,
  output logic                                 done,
  output logic [vrcd_pkg::RADIAL_BITS-1:0]     radial_angle,
  output logic signed [vrcd_pkg::DEV_BITS-1:0] course_deviation,
  output logic                                 to_indicator
);
  import vrcd_pkg::*;

  // stage 1: clamp, round, quadrant
  logic [TBL_W-1:0]        zc;
  logic [TBL_W-1:0]        zr;
  logic signed [ANG_W-1:0] t;
  logic signed [ANG_W-1:0] pre_next;
  logic                    dx_pos;
  logic                    dy_pos;
  logic                    v1;
  logic signed [ANG_W-1:0] pre;
  logic [COURSE_BITS-1:0]  course1;

  always_comb begin
    if (z_in[ZW-1]) begin
      zc = '0;
    end else if (z_in > $signed({1'b0, QUARTER_IN})) begin
      zc = QUARTER_IN;
    end else begin
      zc = z_in[TBL_W-1:0];
    end
    zr = zc + RND_HALF;
    if (side_in.dx_zero) begin
      t = '0;
    end else if (side_in.dy_zero) begin
      t = QUARTER_ANG;
    end else begin
      t = $signed(ANG_W'(zr[TBL_W-1:RND_SH]));
    end
    dx_pos = !side_in.dx_zero && !side_in.dx_neg;
    dy_pos = !side_in.dy_zero && !side_in.dy_neg;
    if (dx_pos && side_in.dy_neg) begin
      pre_next = HALF_ANG - t;
    end else if (dx_pos && dy_pos) begin
      pre_next = t;
    end else if (side_in.dx_neg && dy_pos) begin
      pre_next = FULL_ANG - t;
    end else begin
      pre_next = HALF_ANG + t;
    end
  end

  // stage 2: variation and wrap into 0..360
  logic signed [ANG_W-1:0] rv;
  logic signed [ANG_W-1:0] radial_next;
  logic                    v2;
  logic [RADIAL_BITS-1:0]  radial2;
  logic [COURSE_BITS-1:0]  course2;

  always_comb begin
    rv = pre - ANG_W'(variation);
    if (rv[ANG_W-1]) begin
      radial_next = rv + FULL_ANG;
    end else if (rv > FULL_ANG) begin
      radial_next = rv - FULL_ANG;
    end else begin
      radial_next = rv;
    end
  end

  // stage 3: deviation wrap and to/from reflection
  logic signed [ANG_W-1:0] d0;
  logic signed [ANG_W-1:0] d1;
  logic signed [ANG_W-1:0] d2;
  logic signed [ANG_W-1:0] dev_next;
  logic                    to_next;

  always_comb begin
    d0 = $signed(ANG_W'(radial2)) - $signed(ANG_W'(course2));
    d1 = (d0 > HALF_ANG) ? d0 - FULL_ANG : d0;
    d2 = (d1 < -HALF_ANG) ? d1 + FULL_ANG : d1;
    if (d2 >= QUARTER_ANG) begin
      dev_next = HALF_ANG - d2;
      to_next  = 1'b1;
    end else if (d2 <= -QUARTER_ANG) begin
      dev_next = -(d2 + HALF_ANG);
      to_next  = 1'b1;
    end else begin
      dev_next = d2;
      to_next  = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= valid_in;
      v2   <= v1;
      done <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pre              <= pre_next;
    course1          <= side_in.course;
    radial2          <= radial_next[RADIAL_BITS-1:0];
    course2          <= course1;
    radial_angle     <= radial2;
    course_deviation <= dev_next[DEV_BITS-1:0];
    to_indicator     <= to_next;
  end

endmodule

// File: hdl/vor_radial_cdi_deviation_top.sv
// VOR radial and course deviation, fully pipelined.
// A request passes the difference and magnitude registers, the CORDIC stages and the angle stages before done rises.
// Throughput: one request per cycle; busy is always low, set by one CORDIC stage per rotation.
// Reset (rst, synchronous): clears all valid bits and the station and variation registers.
// Results cannot be stalled by the receiver; done is high for exactly one cycle per request.
module vor_radial_cdi_deviation_top #(
  parameter int POS_BITS = 24,
  parameter int ARCTAN_STAGES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [POS_BITS-1:0]                aircraft_x,
  input  logic signed [POS_BITS-1:0]                aircraft_y,
  input  logic [vrcd_pkg::COURSE_BITS-1:0]          selected_course,
  output logic                                      done,
  output logic [vrcd_pkg::RADIAL_BITS-1:0]          radial_angle,
  output logic signed [vrcd_pkg::DEV_BITS-1:0]      course_deviation,
  output logic                                      to_indicator,
  input  logic                                      wr_en,
  input  logic [vrcd_pkg::CFG_INDEX_BITS-1:0]       wr_index,
  input  logic [vrcd_pkg::CFG_DATA_BITS-1:0]        wr_data
);
  import vrcd_pkg::*;

  localparam int DW = ((POS_BITS > STATION_BITS) ? POS_BITS : STATION_BITS) + 1;
  localparam int CW = DW + 3;

  // configuration registers
  logic signed [STATION_BITS-1:0] station_x;
  logic signed [STATION_BITS-1:0] station_y;
  logic signed [VAR_BITS-1:0]     magnetic_variation;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_x          <= '0;
      station_y          <= '0;
      magnetic_variation <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_STATION_X: station_x          <= wr_data[STATION_BITS-1:0];
        REG_STATION_Y: station_y          <= wr_data[STATION_BITS-1:0];
        REG_MAG_VAR:   magnetic_variation <= wr_data[VAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage a: position differences
  logic                   req;
  logic signed [DW-1:0]   dx_next;
  logic signed [DW-1:0]   dy_next;
  logic                   va;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic [COURSE_BITS-1:0] course_a;

  assign req = start && !busy;
  assign dx_next = {{(DW-POS_BITS){aircraft_x[POS_BITS-1]}}, aircraft_x}
                 - {{(DW-STATION_BITS){station_x[STATION_BITS-1]}}, station_x};
  assign dy_next = {{(DW-POS_BITS){aircraft_y[POS_BITS-1]}}, aircraft_y}
                 - {{(DW-STATION_BITS){station_y[STATION_BITS-1]}}, station_y};

  // stage b: magnitudes and sign flags
  logic [DW-1:0]        dx_abs;
  logic [DW-1:0]        dy_abs;
  side_t                side_next;
  logic                 vb;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  side_t                side_b;

  always_comb begin
    dx_abs = dx[DW-1] ? DW'(-dx) : DW'(dx);
    dy_abs = dy[DW-1] ? DW'(-dy) : DW'(dy);
    side_next.course  = course_a;
    side_next.dx_zero = (dx == '0);
    side_next.dx_neg  = dx[DW-1];
    side_next.dy_zero = (dy == '0);
    side_next.dy_neg  = dy[DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= req;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    dx       <= dx_next;
    dy       <= dy_next;
    course_a <= selected_course;
    x0       <= $signed({3'b000, dy_abs});
    y0       <= $signed({3'b000, dx_abs});
    side_b   <= side_next;
  end

  // arctangent pipeline
  logic                 vc;
  logic signed [ZW-1:0] z_c;
  side_t                side_c;

  vrcd_cordic #(
    .CW            (CW),
    .ARCTAN_STAGES (ARCTAN_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vb),
    .x_in      (x0),
    .y_in      (y0),
    .side_in   (side_b),
    .valid_out (vc),
    .z_out     (z_c),
    .side_out  (side_c)
  );

  // quadrant, variation and deviation
  vrcd_angle u_angle (
    .clk              (clk),
    .rst              (rst),
    .valid_in         (vc),
    .z_in             (z_c),
    .side_in          (side_c),
    .variation        (magnetic_variation),
    .done             (done),
    .radial_angle     (radial_angle),
    .course_deviation (course_deviation),
    .to_indicator     (to_indicator)
  );

endmodule
